// ===== src/assert_macros.svh =====
// assertion helpers, compiled away for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BZY_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BZY_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BZY_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BZY_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/bzy_pkg.sv =====
package bzy_pkg;

  // field widths
  localparam int CO_W      = 32;
  localparam int PI_W      = 6;
  localparam int IT_W      = 7;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int SEGCNT_W  = 5;
  localparam int TOL_W     = 16;

  // internal datapath widths
  localparam int T_W    = 18;           // t, bracket ends
  localparam int W_W    = 20;           // bernstein weights
  localparam int F_W    = 36;           // curve value minus X
  localparam int MA_W   = 36;           // multiplier operand a
  localparam int MB_W   = 32;           // multiplier operand b
  localparam int P_W    = MA_W + MB_W;  // product and accumulator
  localparam int DIVN_W = 54;           // dividend and quotient
  localparam int DIVD_W = 37;           // divisor

  localparam logic signed [T_W-1:0] T_LOW   = -18'sd655;
  localparam logic signed [T_W-1:0] T_HIGH  = 18'sd66191;
  localparam logic signed [T_W:0]   ONE_Q16 = 19'sd65536;
  localparam logic [IT_W-1:0]       ITER_CAP = 7'd64;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_CLAMPED = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT   = 2'd2;
  localparam logic [ST_W-1:0] ST_DEGEN   = 2'd3;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_CNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_T_TOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  // register reset values
  localparam logic signed [CO_W-1:0] RST_Y_GAIN   = 32'sd65536;
  localparam logic signed [CO_W-1:0] RST_Y_OFFSET = 32'sd0;
  localparam logic [SEGCNT_W-1:0]    RST_SEG_CNT  = 5'd1;
  localparam logic [TOL_W-1:0]       RST_T_TOL    = 16'd66;
  localparam logic [IT_W-1:0]        RST_MAX_ITER = 7'd32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PT_RD,
    S_PT_CAP,
    S_PT_MUL,
    S_PT_SCL,
    S_BZ_MUL,
    S_BZ_ACC,
    S_FA,
    S_FB,
    S_CHECK,
    S_DMUL,
    S_DCAP,
    S_DIV,
    S_NEWC,
    S_FC,
    S_YOUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [CO_W-1:0] y_gain;
    logic signed [CO_W-1:0] y_offset;
    logic [SEGCNT_W-1:0]    segment_count;
    logic [TOL_W-1:0]       t_tolerance;
    logic [IT_W-1:0]        max_iterations;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // q16 product reduction, rounding half up
  function automatic logic signed [P_W-1:0] rnd16(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] s;
    s = v + P_W'(32768);
    return s >>> 16;
  endfunction

endpackage

// ===== src/bzy_if.sv =====
// input channel
interface bzy_in_if import bzy_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [PI_W-1:0]        point_index;
  logic signed [CO_W-1:0] x_value;
  logic signed [CO_W-1:0] y_value;

  modport source (output valid, kind, point_index, x_value, y_value, input ready);
  modport sink   (input valid, kind, point_index, x_value, y_value, output ready);
endinterface

// result channel
interface bzy_out_if import bzy_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [CO_W-1:0] y_result;
  logic [IT_W-1:0]        iterations;
  logic [ST_W-1:0]        status;

  modport source (output valid, y_result, iterations, status, input ready);
  modport sink   (input valid, y_result, iterations, status, output ready);
endinterface

// configuration write channel
interface bzy_cfg_if import bzy_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bezier_y_from_x_evaluator.sv =====
// channel   port    direction  payload
// input     in_ch   sink       kind, point_index, x_value, y_value
// result    out_ch  source     y_result, iterations, status
// config    cfg_ch  sink       index, data (always ready)
//
// a load is written as it is accepted and leaves the input ready; a query searches the segments,
// fetches and scales the four points, evaluates the curve on the shared multiplier, and runs
// regula falsi steps, each set by the 54-step bit-serial divider
// synchronous active-low reset clears control and config; the point store is not cleared
// the next item is taken while a finished result waits; a query that finishes while the
// result register is still full holds until it is taken
`include "assert_macros.svh"

module bezier_y_from_x_evaluator import bzy_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  bzy_in_if.sink    in_ch,
  bzy_out_if.source out_ch,
  bzy_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = MAX_SEGMENTS * 4;
  localparam int AW    = $clog2(DEPTH);

  cfg_t cfg_r;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic signed [CO_W-1:0] mem_wx;
  logic signed [CO_W-1:0] mem_wy;
  logic [AW-1:0]          mem_raddr;
  logic signed [CO_W-1:0] mem_rx;
  logic signed [CO_W-1:0] mem_ry;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.y_gain         <= RST_Y_GAIN;
      cfg_r.y_offset       <= RST_Y_OFFSET;
      cfg_r.segment_count  <= RST_SEG_CNT;
      cfg_r.t_tolerance    <= RST_T_TOL;
      cfg_r.max_iterations <= RST_MAX_ITER;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_Y_GAIN:   cfg_r.y_gain         <= CO_W'(cfg_ch.data);
        CFG_Y_OFFSET: cfg_r.y_offset       <= CO_W'(cfg_ch.data);
        CFG_SEG_CNT:  cfg_r.segment_count  <= cfg_ch.data[SEGCNT_W-1:0];
        CFG_T_TOL:    cfg_r.t_tolerance    <= cfg_ch.data[TOL_W-1:0];
        CFG_MAX_ITER: cfg_r.max_iterations <= cfg_ch.data[IT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control point store
  bzy_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wx    (mem_wx),
    .wy    (mem_wy),
    .raddr (mem_raddr),
    .rx_r  (mem_rx),
    .ry_r  (mem_ry)
  );

  // sequencer and datapath
  bzy_core #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wx    (mem_wx),
    .mem_wy    (mem_wy),
    .mem_raddr (mem_raddr),
    .mem_rx    (mem_rx),
    .mem_ry    (mem_ry)
  );

  // checks
  `BZY_ASSERT_NXT(a_query_busy, clk, rst_n, in_ch.valid && in_ch.ready && (in_ch.kind == KIND_QUERY), !in_ch.ready, "query did not start")
  `BZY_ASSERT_NXT(a_load_single, clk, rst_n, in_ch.valid && in_ch.ready && (in_ch.kind == KIND_LOAD), in_ch.ready, "load held the input")
  `BZY_ASSERT_IMP(a_iter_nonzero, clk, rst_n, out_ch.valid && (out_ch.status != ST_DEGEN), out_ch.iterations != '0, "result without an estimate")
  `BZY_ASSERT_IMP(a_iter_cap, clk, rst_n, out_ch.valid, out_ch.iterations <= ITER_CAP, "iteration count over cap")

endmodule

// ===== src/bzy_store.sv =====
module bzy_store import bzy_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic signed [CO_W-1:0] wx,
  input  logic signed [CO_W-1:0] wy,
  input  logic [AW-1:0]          raddr,
  output logic signed [CO_W-1:0] rx_r,
  output logic signed [CO_W-1:0] ry_r
);

  logic signed [CO_W-1:0] mem_x [DEPTH];
  logic signed [CO_W-1:0] mem_y [DEPTH];

  // x control points
  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
    end
    rx_r <= mem_x[raddr];
  end

  // y control points
  always_ff @(posedge clk) begin
    if (we) begin
      mem_y[waddr] <= wy;
    end
    ry_r <= mem_y[raddr];
  end

endmodule

// ===== src/bzy_mul.sv =====
module bzy_mul import bzy_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [P_W-1:0]  prod_r
);

  // registered signed product
  always_ff @(posedge clk) begin
    prod_r <= P_W'(a) * P_W'(b);
  end

endmodule

// ===== src/bzy_div.sv =====
module bzy_div import bzy_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIVN_W-1:0] dividend,
  input  logic signed [DIVD_W-1:0] divisor,
  output logic signed [DIVN_W-1:0] quot,
  output div_stat_t                stat
);

  localparam int CW = $clog2(DIVN_W + 1);

  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [DIVN_W-1:0] nmag_r;
  logic [DIVD_W-1:0] dmag_r;
  logic [DIVD_W-1:0] rem_r;

  logic [DIVD_W:0]   trial;
  logic [DIVD_W+1:0] diff;
  logic              qbit;
  logic [DIVD_W-1:0] rem_nxt;

  // one restoring step
  always_comb begin
    trial   = {rem_r, nmag_r[DIVN_W-1]};
    diff    = {1'b0, trial} - {2'b00, dmag_r};
    qbit    = ~diff[DIVD_W+1];
    rem_nxt = qbit ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitudes and shift register
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[DIVN_W-1] ^ divisor[DIVD_W-1];
      nmag_r <= dividend[DIVN_W-1] ? DIVN_W'(-dividend) : DIVN_W'(dividend);
      dmag_r <= divisor[DIVD_W-1] ? DIVD_W'(-divisor) : DIVD_W'(divisor);
      rem_r  <= '0;
    end else if (busy_r) begin
      nmag_r <= {nmag_r[DIVN_W-2:0], qbit};
      rem_r  <= rem_nxt;
    end
  end

  // truncation toward zero
  assign quot = neg_r ? -$signed(nmag_r) : $signed(nmag_r);
  assign stat = '{busy: busy_r, done: done_r};

endmodule

// ===== src/bzy_core.sv =====
module bzy_core import bzy_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_WIDTH  = 32,
  parameter int DEPTH        = 64,
  parameter int AW           = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  bzy_in_if.sink                 in_ch,
  bzy_out_if.source              out_ch,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic signed [CO_W-1:0] mem_wx,
  output logic signed [CO_W-1:0] mem_wy,
  output logic [AW-1:0]          mem_raddr,
  input  logic signed [CO_W-1:0] mem_rx,
  input  logic signed [CO_W-1:0] mem_ry
);

  localparam int SEGW     = $clog2(MAX_SEGMENTS + 1);
  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam longint SAT_HI_L = (longint'(1) <<< (SAT_BITS - 1)) - 1;
  localparam logic signed [P_W-1:0] SAT_HI = P_W'(SAT_HI_L);
  localparam logic signed [P_W-1:0] SAT_LO = -SAT_HI - P_W'(1);
  localparam logic [7:0] MAXS8  = 8'(MAX_SEGMENTS);
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  function automatic logic signed [CO_W-1:0] sat_c(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] r;
    r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return CO_W'(r);
  endfunction

  state_t state_r, state_nxt, bz_ret_r;

  logic [3:0]             bstep_r;
  logic                   sel_y_r;
  logic [SEGW-1:0]        seg_r;
  logic [1:0]             pj_r;
  logic signed [CO_W-1:0] xv_r, yraw_r;
  logic signed [CO_W-1:0] px_r [4];
  logic signed [CO_W-1:0] py_r [4];
  logic signed [T_W-1:0]  t_r, a_r, b_r, c_r, prev_r;
  logic signed [W_W-1:0]  uu_r, uuu_r, tt_r, ttt_r, w1_r, w2_r;
  logic signed [P_W-1:0]  acc_r;
  logic signed [F_W-1:0]  fa_r, fb_r;
  logic [IT_W-1:0]        iter_r;
  logic                   clamped_r, limited_r, degen_r;
  logic signed [CO_W-1:0] res_y_r;
  logic [IT_W-1:0]        res_it_r;
  logic [ST_W-1:0]        res_st_r;
  logic                   out_valid_r;

  logic                     in_acc, is_query;
  logic [8:0]               slot9;
  logic [7:0]               nraw8, nseg8;
  logic [SEGW-1:0]          nseg;
  logic                     seg_last;
  logic [IT_W-1:0]          lim;
  logic signed [T_W:0]      u_w;
  logic signed [T_W-1:0]    u;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod;
  logic signed [P_W-1:0]    rnd_p;
  logic signed [F_W-1:0]    bz;
  logic signed [F_W-1:0]    fx;
  logic signed [CO_W-1:0]   pval;
  logic                     div_start;
  logic signed [DIVN_W-1:0] quot;
  div_stat_t                div_stat;
  logic signed [DIVN_W-1:0] cfull;
  logic signed [T_W-1:0]    cclamp;
  logic signed [T_W:0]      dlt;
  logic [T_W:0]             dabs;
  logic                     conv;
  logic                     stop;
  logic                     out_free;

  // shared units
  bzy_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  bzy_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVN_W'(prod)),
    .divisor  (DIVD_W'(fb_r) - DIVD_W'(fa_r)),
    .quot     (quot),
    .stat     (div_stat)
  );

  // effective limits and derived values
  always_comb begin
    in_acc   = in_ch.valid & in_ch.ready;
    is_query = (in_ch.kind == KIND_QUERY);
    slot9    = 9'(in_ch.point_index);
    nraw8    = 8'(cfg.segment_count);
    if (nraw8 == 8'd0) begin
      nseg8 = 8'd1;
    end else if (nraw8 > MAXS8) begin
      nseg8 = MAXS8;
    end else begin
      nseg8 = nraw8;
    end
    nseg     = nseg8[SEGW-1:0];
    seg_last = ((SEGW+1)'(seg_r) + (SEGW+1)'(1)) == (SEGW+1)'(nseg);
    if (cfg.max_iterations == '0) begin
      lim = IT_W'(1);
    end else if (cfg.max_iterations > ITER_CAP) begin
      lim = ITER_CAP;
    end else begin
      lim = cfg.max_iterations;
    end
    u_w   = ONE_Q16 - (T_W+1)'(t_r);
    u     = u_w[T_W-1:0];
    rnd_p = rnd16(prod);
    bz    = F_W'(rnd16(acc_r));
    fx    = bz - F_W'(xv_r);
    case (bstep_r)
      4'd6:    pval = sel_y_r ? py_r[0] : px_r[0];
      4'd7:    pval = sel_y_r ? py_r[1] : px_r[1];
      4'd8:    pval = sel_y_r ? py_r[2] : px_r[2];
      default: pval = sel_y_r ? py_r[3] : px_r[3];
    endcase
    cfull = DIVN_W'(b_r) - quot;
    if (cfull < DIVN_W'(T_LOW)) begin
      cclamp = T_LOW;
    end else if (cfull > DIVN_W'(T_HIGH)) begin
      cclamp = T_HIGH;
    end else begin
      cclamp = T_W'(cfull);
    end
    dlt      = (T_W+1)'(prev_r) - (T_W+1)'(c_r);
    dabs     = dlt[T_W] ? (T_W+1)'(-dlt) : (T_W+1)'(dlt);
    conv     = (iter_r >= IT_W'(2)) && (dabs <= (T_W+1)'(cfg.t_tolerance));
    stop     = (iter_r >= lim) || (fb_r == fa_r);
    out_free = ~out_valid_r | out_ch.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc && is_query) state_nxt = S_SRCH_RD;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = (xv_r > mem_rx && !seg_last) ? S_SRCH_RD : S_PT_RD;
      S_PT_RD:    state_nxt = S_PT_CAP;
      S_PT_CAP:   state_nxt = S_PT_MUL;
      S_PT_MUL:   state_nxt = S_PT_SCL;
      S_PT_SCL:   state_nxt = (pj_r == 2'd3) ? S_BZ_MUL : S_PT_RD;
      S_BZ_MUL:   state_nxt = S_BZ_ACC;
      S_BZ_ACC:   state_nxt = (bstep_r == 4'd9) ? bz_ret_r : S_BZ_MUL;
      S_FA:       state_nxt = S_BZ_MUL;
      S_FB:       state_nxt = S_CHECK;
      S_CHECK:    state_nxt = stop ? S_BZ_MUL : S_DMUL;
      S_DMUL:     state_nxt = S_DCAP;
      S_DCAP:     state_nxt = S_DIV;
      S_DIV:      if (div_stat.done) state_nxt = S_NEWC;
      S_NEWC:     state_nxt = S_BZ_MUL;
      S_FC:       state_nxt = conv ? S_BZ_MUL : S_CHECK;
      S_YOUT:     state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    mem_we      = in_acc && (in_ch.kind == KIND_LOAD) && (slot9 < DEPTH9);
    mem_waddr   = slot9[AW-1:0];
    mem_wx      = in_ch.x_value;
    mem_wy      = in_ch.y_value;
    mem_raddr   = (state_r == S_PT_RD) ? AW'({seg_r, pj_r}) : AW'({seg_r, 2'b11});
    div_start   = (state_r == S_DCAP);
    mul_a       = '0;
    mul_b       = '0;
    case (state_r)
      S_PT_MUL: begin
        mul_a = MA_W'(yraw_r);
        mul_b = MB_W'(cfg.y_gain);
      end
      S_DMUL: begin
        mul_a = MA_W'(fb_r);
        mul_b = MB_W'((T_W+1)'(b_r) - (T_W+1)'(a_r));
      end
      S_BZ_MUL, S_BZ_ACC: begin
        case (bstep_r)
          4'd0: begin mul_a = MA_W'(u);    mul_b = MB_W'(u);     end
          4'd1: begin mul_a = MA_W'(uu_r); mul_b = MB_W'(u);     end
          4'd2: begin mul_a = MA_W'(t_r);  mul_b = MB_W'(t_r);   end
          4'd3: begin mul_a = MA_W'(tt_r); mul_b = MB_W'(t_r);   end
          4'd4: begin mul_a = MA_W'(t_r);  mul_b = MB_W'(uu_r);  end
          4'd5: begin mul_a = MA_W'(tt_r); mul_b = MB_W'(u);     end
          4'd6: begin mul_a = MA_W'(pval); mul_b = MB_W'(uuu_r); end
          4'd7: begin mul_a = MA_W'(pval); mul_b = MB_W'(w1_r);  end
          4'd8: begin mul_a = MA_W'(pval); mul_b = MB_W'(w2_r);  end
          default: begin mul_a = MA_W'(pval); mul_b = MB_W'(ttt_r); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    out_ch.valid      = out_valid_r;
    out_ch.y_result   = res_y_r;
    out_ch.iterations = res_it_r;
    out_ch.status     = res_st_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_query) begin
          xv_r      <= in_ch.x_value;
          seg_r     <= '0;
          clamped_r <= 1'b0;
          limited_r <= 1'b0;
          degen_r   <= 1'b0;
        end
      end
      S_SRCH_CMP: begin
        pj_r <= 2'd0;
        if (xv_r > mem_rx) begin
          if (seg_last) begin
            clamped_r <= 1'b1;
          end else begin
            seg_r <= seg_r + SEGW'(1);
          end
        end
      end
      S_PT_CAP: begin
        px_r[pj_r] <= mem_rx;
        yraw_r     <= mem_ry;
      end
      S_PT_SCL: begin
        py_r[pj_r] <= sat_c(rnd_p + P_W'(cfg.y_offset));
        pj_r       <= pj_r + 2'd1;
        t_r        <= T_LOW;
        sel_y_r    <= 1'b0;
        bstep_r    <= 4'd0;
        bz_ret_r   <= S_FA;
      end
      S_BZ_ACC: begin
        bstep_r <= bstep_r + 4'd1;
        case (bstep_r)
          4'd0: uu_r  <= W_W'(rnd_p);
          4'd1: uuu_r <= W_W'(rnd_p);
          4'd2: tt_r  <= W_W'(rnd_p);
          4'd3: ttt_r <= W_W'(rnd_p);
          4'd4: w1_r  <= W_W'(rnd_p + (rnd_p <<< 1));
          4'd5: w2_r  <= W_W'(rnd_p + (rnd_p <<< 1));
          4'd6: acc_r <= prod;
          default: acc_r <= acc_r + prod;
        endcase
      end
      S_FA: begin
        fa_r     <= fx;
        t_r      <= T_HIGH;
        bstep_r  <= 4'd0;
        bz_ret_r <= S_FB;
      end
      S_FB: begin
        // order the bracket so that fa holds the lower curve value
        if (fa_r > fx) begin
          a_r  <= T_HIGH;
          b_r  <= T_LOW;
          fa_r <= fx;
          fb_r <= fa_r;
        end else begin
          a_r  <= T_LOW;
          b_r  <= T_HIGH;
          fb_r <= fx;
        end
        iter_r <= '0;
        c_r    <= '0;
      end
      S_CHECK: begin
        if (iter_r >= lim) begin
          limited_r <= 1'b1;
        end else if (fb_r == fa_r) begin
          degen_r <= 1'b1;
        end
        t_r      <= c_r;
        sel_y_r  <= 1'b1;
        bstep_r  <= 4'd0;
        bz_ret_r <= S_YOUT;
      end
      S_NEWC: begin
        prev_r   <= c_r;
        c_r      <= cclamp;
        iter_r   <= iter_r + IT_W'(1);
        t_r      <= cclamp;
        sel_y_r  <= 1'b0;
        bstep_r  <= 4'd0;
        bz_ret_r <= S_FC;
      end
      S_FC: begin
        if (fx > 0) begin
          b_r  <= c_r;
          fb_r <= fx;
        end else begin
          a_r  <= c_r;
          fa_r <= fx;
        end
        t_r      <= c_r;
        sel_y_r  <= 1'b1;
        bstep_r  <= 4'd0;
        bz_ret_r <= S_YOUT;
      end
      // result register loads only once the previous result has gone
      S_DONE: begin
        if (out_free) begin
          res_y_r  <= sat_c(P_W'(bz));
          res_it_r <= iter_r;
          if (degen_r) begin
            res_st_r <= ST_DEGEN;
          end else if (limited_r) begin
            res_st_r <= ST_LIMIT;
          end else if (clamped_r) begin
            res_st_r <= ST_CLAMPED;
          end else begin
            res_st_r <= ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
